// ===== src/amst_pkg.sv =====
`timescale 1ns / 1ps

package amst_pkg;

	localparam int STACK_DEPTH = 10;
	localparam int FRAC_BITS   = 16;
	localparam int WORD_W      = 32;
	localparam int PROD_W      = 2 * WORD_W;
	// A truncated product keeps PROD_W - FRAC_BITS bits; three of them need two more.
	localparam int SUM_W       = PROD_W - FRAC_BITS + 2;
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int MAT_N       = 9;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef word_t [MAT_N-1:0]        mat_t;

	typedef enum logic [2:0] {
		FN_PUSH      = 3'd0,
		FN_POP       = 3'd1,
		FN_PUSH_ID   = 3'd2,
		FN_TRANSLATE = 3'd3,
		FN_SCALE     = 3'd4,
		FN_SHEAR     = 3'd5,
		FN_POINT     = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} stk_flags_t;

	localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

	function automatic mat_t ident();
		mat_t m;
		for (int i = 0; i < MAT_N; i++) begin
			m[i] = (i == 0 || i == 4 || i == 8) ? ONE : '0;
		end
		return m;
	endfunction

	// Exact product, then an arithmetic shift: rounds toward minus infinity.
	function automatic sum_t fx_mul(word_t a, word_t b);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		return SUM_W'(p >>> FRAC_BITS);
	endfunction

	function automatic sum_t ext(word_t a);
		return SUM_W'(a);
	endfunction

	function automatic word_t sat(sum_t v);
		word_t r;
		if (v[SUM_W-1:WORD_W-1] == '0 || v[SUM_W-1:WORD_W-1] == '1) begin
			r = v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== src/amst_alu.sv =====
`timescale 1ns / 1ps

module amst_alu (
	input  amst_pkg::func_t func,
	input  amst_pkg::word_t arg_x,
	input  amst_pkg::word_t arg_y,
	input  amst_pkg::word_t arg_z,
	input  amst_pkg::mat_t  mat,
	output amst_pkg::mat_t  mat_next,
	output amst_pkg::word_t pt_x,
	output amst_pkg::word_t pt_y,
	output amst_pkg::word_t pt_z
);
	import amst_pkg::*;

	word_t args [3];
	word_t m    [MAT_N];
	sum_t  prod [MAT_N];
	word_t pt   [3];

	assign args[0] = arg_x;
	assign args[1] = arg_y;
	assign args[2] = arg_z;

	// Column k of every row is always multiplied by argument k. That one set of
	// nine products serves the point transform and all three post-multiplies.
	always_comb begin
		for (int i = 0; i < MAT_N; i++) begin
			m[i]    = mat[i];
			prod[i] = fx_mul(m[i], args[i % 3]);
		end
	end

	always_comb begin
		mat_next = mat;
		for (int r = 0; r < 3; r++) begin
			pt[r] = sat(prod[3*r] + prod[3*r+1] + prod[3*r+2]);
			case (func)
				FN_TRANSLATE: begin
					mat_next[3*r+2] = sat(prod[3*r] + prod[3*r+1] + ext(m[3*r+2]));
				end
				FN_SCALE: begin
					mat_next[3*r]   = sat(prod[3*r]);
					mat_next[3*r+1] = sat(prod[3*r+1]);
				end
				FN_SHEAR: begin
					mat_next[3*r]   = sat(ext(m[3*r]) + prod[3*r+1]);
					mat_next[3*r+1] = sat(prod[3*r] + ext(m[3*r+1]));
				end
				default: begin
				end
			endcase
		end
	end

	assign pt_x = pt[0];
	assign pt_y = pt[1];
	assign pt_z = pt[2];

endmodule

// ===== src/amst_stack.sv =====
`timescale 1ns / 1ps

module amst_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amst_pkg::stk_cmd_t   cmd,
	input  amst_pkg::mat_t       cur,
	output amst_pkg::mat_t       top,
	output amst_pkg::stk_flags_t flags
);
	import amst_pkg::*;

	// The top entry and the one below it live in registers so that a pop can
	// take its new top straight from a register; deeper entries sit in the array.
	mat_t             mem [STACK_DEPTH];
	mat_t             top_q;
	mat_t             below_q;
	logic [PTR_W-1:0] sp_q;
	logic [PTR_W-1:0] sp_m1;
	logic [PTR_W-1:0] sp_m3;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign sp_m1   = sp_q - PTR_W'(1);
	assign sp_m3   = sp_q - PTR_W'(3);
	assign wr_addr = sp_m1[ADDR_W-1:0];
	assign rd_addr = sp_m3[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + PTR_W'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (sp_q != '0) begin
				mem[wr_addr] <= top_q;
			end
			top_q   <= cur;
			below_q <= top_q;
		end else if (cmd.pop) begin
			top_q   <= below_q;
			below_q <= mem[rd_addr];
		end
	end

	assign top         = top_q;
	assign flags.full  = (sp_q == PTR_W'(STACK_DEPTH));
	assign flags.empty = (sp_q == '0);

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PTR_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	a_push_guard: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !flags.full && !cmd.pop)
		else $error("push on full stack or push with pop");
	a_pop_guard: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !flags.empty)
		else $error("pop on empty stack");
	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> top_q == $past(cur) && sp_q == $past(sp_q) + PTR_W'(1))
		else $error("push did not update top");

endmodule

// ===== src/affine_matrix_stack_transform.sv =====
`timescale 1ns / 1ps

// Affine matrix stack: holds a current 3x3 Q16.16 matrix and a stack of saved
// matrices, and runs one command per input word (push, pop, push identity,
// translate, scale, shear, transform point).
// Input channel: in_valid/in_stall with func, arg_x, arg_y, arg_z. A word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with out_x, out_y, out_z and status;
// every input word gives exactly one output word. Point components are zero
// for all commands other than transform point.
// Path: a word taken at an edge is held in the input register, worked on
// there by nine parallel 32x32 multipliers and the add/saturate logic, and
// then registered in the output register, from which the receiver takes it.
// Throughput: one word per cycle while the receiver does not stall; the matrix
// and stack update in the same cycle in which the command leaves for the output
// register, so the next command always sees the new state.
// When the receiver stalls, the output word holds, the command in the input
// register waits, and in_stall rises while that register is occupied.
// Reset loads the identity matrix and empties the stack; no words are held.

module affine_matrix_stack_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic signed [31:0] arg_x,
	input  logic signed [31:0] arg_y,
	input  logic signed [31:0] arg_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]  status
);
	import amst_pkg::*;

	logic       valid_s1;
	func_t      func_s1;
	word_t      ax_s1;
	word_t      ay_s1;
	word_t      az_s1;

	mat_t       cur_q;
	mat_t       alu_mat;
	mat_t       stk_top;
	word_t      pt_x;
	word_t      pt_y;
	word_t      pt_z;
	stk_cmd_t   stk_cmd;
	stk_flags_t stk_flags;
	status_t    st;

	logic       out_valid_q;
	word_t      ox_q;
	word_t      oy_q;
	word_t      oz_q;
	status_t    status_q;

	logic       advance;
	logic       in_take;
	logic       is_push;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign is_push  = (func_s1 == FN_PUSH) || (func_s1 == FN_PUSH_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= func_t'(func);
			ax_s1   <= arg_x;
			ay_s1   <= arg_y;
			az_s1   <= arg_z;
		end
	end

	amst_alu u_alu (
		.func     (func_s1),
		.arg_x    (ax_s1),
		.arg_y    (ay_s1),
		.arg_z    (az_s1),
		.mat      (cur_q),
		.mat_next (alu_mat),
		.pt_x     (pt_x),
		.pt_y     (pt_y),
		.pt_z     (pt_z)
	);

	amst_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.cur    (cur_q),
		.top    (stk_top),
		.flags  (stk_flags)
	);

	always_comb begin
		stk_cmd.push = advance && is_push && !stk_flags.full;
		stk_cmd.pop  = advance && (func_s1 == FN_POP) && !stk_flags.empty;
		st = ST_OK;
		if (is_push && stk_flags.full) begin
			st = ST_FULL;
		end else if (func_s1 == FN_POP && stk_flags.empty) begin
			st = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= ident();
		end else if (advance) begin
			case (func_s1)
				FN_PUSH_ID: begin
					if (!stk_flags.full) begin
						cur_q <= ident();
					end
				end
				FN_POP: begin
					if (!stk_flags.empty) begin
						cur_q <= stk_top;
					end
				end
				FN_TRANSLATE, FN_SCALE, FN_SHEAR: begin
					cur_q <= alu_mat;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ox_q     <= (func_s1 == FN_POINT) ? pt_x : '0;
			oy_q     <= (func_s1 == FN_POINT) ? pt_y : '0;
			oz_q     <= (func_s1 == FN_POINT) ? pt_z : '0;
			status_q <= st;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_z     = oz_q;
	assign status    = status_q;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced word missing at output");
	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without cause");
	a_err_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> ox_q == '0 && oy_q == '0 && oz_q == '0)
		else $error("error word carries point data");
	a_hold_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(cur_q))
		else $error("matrix changed without a command");

endmodule

// ===== tb/amst_tb_pkg.sv =====
`timescale 1ns / 1ps

package amst_tb_pkg;
	import amst_pkg::*;

	typedef struct {
		word_t   x;
		word_t   y;
		word_t   z;
		status_t st;
	} point_word_t;

	// Mirrors the current matrix and the saved-matrix stack, and queues the
	// output word that each accepted command should produce.
	class matrix_stack_mirror;
		word_t       cur_mat[MAT_N];
		word_t       saved_mat[STACK_DEPTH][MAT_N];
		int          depth;
		int          errors;
		point_word_t expected_points[$];

		function new();
			set_identity();
			depth = 0;
			errors = 0;
		endfunction

		function void set_identity();
			for (int i = 0; i < MAT_N; i++) begin
				cur_mat[i] = (i % 4 == 0) ? ONE : '0;
			end
		endfunction

		// The exact product shifted right, so it rounds toward minus infinity.
		function longint scaled_product(word_t a, word_t b);
			return (longint'(a) * longint'(b)) >>> FRAC_BITS;
		endfunction

		function word_t clamp(longint v);
			if (v > 64'sd2147483647) begin
				return 32'sh7fffffff;
			end
			if (v < -64'sd2147483648) begin
				return 32'sh80000000;
			end
			return word_t'(v);
		endfunction

		function word_t row_dot(int row, word_t ax, word_t ay, word_t az);
			return clamp(scaled_product(cur_mat[row * 3], ax)
				+ scaled_product(cur_mat[row * 3 + 1], ay)
				+ scaled_product(cur_mat[row * 3 + 2], az));
		endfunction

		function void post_multiply(word_t t[MAT_N]);
			word_t r[MAT_N];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r[i * 3 + j] = row_dot(i, t[j], t[3 + j], t[6 + j]);
				end
			end
			cur_mat = r;
		endfunction

		function void take_command(logic [2:0] code, word_t ax, word_t ay, word_t az);
			point_word_t w;
			word_t       t[MAT_N];
			w.x = '0;
			w.y = '0;
			w.z = '0;
			w.st = ST_OK;
			for (int i = 0; i < MAT_N; i++) begin
				t[i] = (i % 4 == 0) ? ONE : '0;
			end
			case (func_t'(code))
				FN_PUSH, FN_PUSH_ID: begin
					// A push onto a full stack leaves the matrix alone, even for push identity.
					if (depth >= STACK_DEPTH) begin
						w.st = ST_FULL;
					end else begin
						saved_mat[depth] = cur_mat;
						depth++;
						if (code == FN_PUSH_ID) begin
							set_identity();
						end
					end
				end
				FN_POP: begin
					if (depth == 0) begin
						w.st = ST_EMPTY;
					end else begin
						depth--;
						cur_mat = saved_mat[depth];
					end
				end
				FN_TRANSLATE: begin
					t[2] = ax;
					t[5] = ay;
					post_multiply(t);
				end
				FN_SCALE: begin
					t[0] = ax;
					t[4] = ay;
					post_multiply(t);
				end
				FN_SHEAR: begin
					t[1] = ax;
					t[3] = ay;
					post_multiply(t);
				end
				FN_POINT: begin
					w.x = row_dot(0, ax, ay, az);
					w.y = row_dot(1, ax, ay, az);
					w.z = row_dot(2, ax, ay, az);
				end
				default: begin
				end
			endcase
			expected_points.push_back(w);
		endfunction

		function void check_word(word_t x, word_t y, word_t z, logic [1:0] st);
			point_word_t w;
			if (expected_points.size() == 0) begin
				$error("output word arrived with none expected");
				errors++;
				return;
			end
			w = expected_points.pop_front();
			if (x !== w.x) begin
				$error("out_x: expected %0d, got %0d", w.x, x);
				errors++;
			end
			if (y !== w.y) begin
				$error("out_y: expected %0d, got %0d", w.y, y);
				errors++;
			end
			if (z !== w.z) begin
				$error("out_z: expected %0d, got %0d", w.z, z);
				errors++;
			end
			if (st !== w.st) begin
				$error("status: expected %0d, got %0d", w.st, st);
				errors++;
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

endpackage

// ===== tb/tb_affine_matrix_stack_transform.sv =====
`timescale 1ns / 1ps

module tb_affine_matrix_stack_transform;
	import amst_pkg::*;
	import amst_tb_pkg::*;

	localparam int RANDOM_WORDS = 1700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [2:0] func      = FN_PUSH;
	word_t      arg_x     = '0;
	word_t      arg_y     = '0;
	word_t      arg_z     = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	word_t      out_x;
	word_t      out_y;
	word_t      out_z;
	logic [1:0] status;

	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	bit grow_stack     = 1'b1;
	int cycle_count    = 0;

	matrix_stack_mirror mirror;

	affine_matrix_stack_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.arg_x     (arg_x),
		.arg_y     (arg_y),
		.arg_z     (arg_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.status    (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= receiver_idles && ($urandom_range(99) < 25);
	end

	// Both channels are sampled at the edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				mirror.take_command(func, arg_x, arg_y, arg_z);
			end
			if (out_valid && !out_stall) begin
				mirror.check_word(out_x, out_y, out_z, status);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("affine_matrix_stack_transform regression: fail");
		$finish;
	end

	task automatic send_word(func_t code, word_t ax, word_t ay, word_t az);
		if (sender_idles && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= code;
		arg_x    <= ax;
		arg_y    <= ay;
		arg_z    <= az;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// The extra edge lets the monitor count the last word before the queue is read.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic word_t pick_arg();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3, 4: return word_t'($urandom);
			default: return word_t'($urandom_range(0, 8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	function automatic func_t pick_command(bit grow);
		int roll;
		int push_share;
		int pop_share;
		roll = $urandom_range(99);
		push_share = grow ? 25 : 8;
		pop_share = grow ? 8 : 25;
		if (roll < push_share) begin
			return $urandom_range(1) ? FN_PUSH : FN_PUSH_ID;
		end
		if (roll < push_share + pop_share) begin
			return FN_POP;
		end
		case ($urandom_range(4))
			0: return FN_TRANSLATE;
			1: return FN_SCALE;
			2: return FN_SHEAR;
			default: return FN_POINT;
		endcase
	endfunction

	initial begin
		mirror = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(FN_POINT, 32'sh7fffffff, 32'sh80000000, -ONE);
		send_word(FN_POP, pick_arg(), pick_arg(), pick_arg());
		send_word(FN_SCALE, 32'sh80000000, 32'sh7fffffff, '0);
		send_word(FN_POINT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_word(FN_PUSH_ID, pick_arg(), pick_arg(), pick_arg());
		send_word(FN_TRANSLATE, 32'sh7fffffff, 32'sh80000000, '0);
		send_word(FN_SHEAR, ONE + ONE / 2, 32'sh80000000, '0);
		send_word(FN_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		// Fill the stack, then push twice more onto the full stack.
		for (int i = 0; i < STACK_DEPTH - 1; i++) begin
			send_word((i % 2 == 0) ? FN_PUSH : FN_PUSH_ID, pick_arg(), pick_arg(), pick_arg());
		end
		send_word(FN_PUSH, pick_arg(), pick_arg(), pick_arg());
		send_word(FN_PUSH_ID, pick_arg(), pick_arg(), pick_arg());
		for (int i = 0; i <= STACK_DEPTH; i++) begin
			send_word(FN_POP, pick_arg(), pick_arg(), pick_arg());
		end
		send_word(FN_POINT, ONE, -ONE, 32'sh7fffffff);
		wait_for_results();

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			sender_idles = !(k >= 600 && k < 900);
			receiver_idles <= !(k >= 600 && k < 900);
			if (k % 100 == 0) begin
				grow_stack = $urandom_range(1);
			end
			if (k == 1000) begin
				wait_for_results();
			end
			send_word(pick_command(grow_stack), pick_arg(), pick_arg(), pick_arg());
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("affine_matrix_stack_transform regression: pass");
		end else begin
			$display("affine_matrix_stack_transform regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/amst_pkg.sv
src/amst_alu.sv
src/amst_stack.sv
src/affine_matrix_stack_transform.sv
tb/amst_tb_pkg.sv
tb/tb_affine_matrix_stack_transform.sv
